// File: sv/rcef_pkg.sv
// rcef_pkg: shared types, constants and the gradient magnitude function
// for the Roberts cross edge filter. No dependencies.
package rcef_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_DATA_W = 13;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd480;
    localparam logic [IMG_H_W-1:0] ROW_LIMIT   = 13'd4096;
    localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;

    // register indexes on the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // result slots of one pixel; bit 1 picks the current row, bit 0 the current column
    typedef enum logic [1:0] {
        SLOT_UP_LEFT = 2'd0,
        SLOT_UP      = 2'd1,
        SLOT_LEFT    = 2'd2,
        SLOT_HERE    = 2'd3
    } slot_t;

    // min(|a-b| + |c-d|, 255)
    function automatic logic [PIX_W-1:0] edge_mag(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d
    );
        logic [PIX_W-1:0] dx;
        logic [PIX_W-1:0] dy;
        logic [PIX_W:0]   s;
        dx = (a >= b) ? (a - b) : (b - a);
        dy = (c >= d) ? (c - d) : (d - c);
        s  = {1'b0, dx} + {1'b0, dy};
        return s[PIX_W] ? PIX_MAX : s[PIX_W-1:0];
    endfunction

endpackage

// File: sv/rcef_ram.sv
// rcef_ram: generic single-port RAM, registered read, read-first on a
// write to the address being read. No dependencies.
module rcef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];  // old contents
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/roberts_cross_edge_filter_core.sv
// Roberts cross edge filter core: window control, result sequencing and
// output register. Depends on rcef_pkg and rcef_ram.
//
// Takes 8-bit grayscale pixels in raster order, one transaction per pixel,
// and returns the Roberts cross magnitude min(|gx|+|gy|, 255) of every pixel
// with its row and column. A result leaves as soon as its 2x2 window is
// complete; pixels past the right and bottom edges count as zero, so the
// last column and last row finish early and a pixel can cause zero to four
// results (up-left, up, left, itself). tlast marks the final result caused
// by an input pixel, tuser marks the bottom-right pixel of the frame.
// Rate: a pixel that causes at most one result does not hold the input, so a
// frame body streams at one pixel per clock while the output accepts; a pixel
// causing more results holds the input while the output port moves one
// transaction per cycle. The line store read feeds the result stage, then the
// output register. The previous row lives in one RAM of MAX_WIDTH entries
// that is read and rewritten at the column address in the same cycle.
// Any configuration write restarts the frame at row 0, column 0; width is
// clamped to 1..MAX_WIDTH, height to 1..4096. Write configuration only while
// no pixel is in flight.
module roberts_cross_edge_filter_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,

    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value

    // edge results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] out_row, [21:12] out_col, [29:22] edge_value
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > rcef_pkg::IMG_W_W) ? CW + 1 : rcef_pkg::IMG_W_W;
    localparam int PW = rcef_pkg::PIX_W;
    localparam int RW = rcef_pkg::ROW_W;

    // configuration
    logic [rcef_pkg::IMG_W_W-1:0] image_width_reg;
    logic [rcef_pkg::IMG_H_W-1:0] image_height_reg;

    // frame position of the next pixel
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] col_count_reg;

    // neighbor registers, advanced when an item leaves the result stage
    logic [PW-1:0] left_reg;
    logic [PW-1:0] upleft_reg;

    // result stage
    logic          s1_valid_reg;
    logic [3:0]    s1_mask_reg;
    logic [PW-1:0] s1_cur_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;

    // output register
    logic          m_valid_reg;
    logic [RW-1:0] m_row_reg;
    logic [rcef_pkg::OUT_COL_W-1:0] m_col_reg;
    logic [PW-1:0] m_edge_reg;
    logic          m_last_reg;
    logic          m_frame_reg;

    logic [PW-1:0] above;

    // effective limits
    logic [XW-1:0] width_x;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic [CW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic          last_col;
    logic          last_row;
    logic [3:0]    new_mask;
    logic          accept;

    // sequencing
    rcef_pkg::slot_t sel;
    logic [3:0]    mask_left;
    logic          out_free;
    logic          emit;
    logic          done;

    logic [XW-1:0] col_x;
    logic [XW-1:0] colm1_x;
    logic [RW-1:0] res_row;
    logic [rcef_pkg::OUT_COL_W-1:0] res_col;
    logic [PW-1:0] res_edge;

    always_comb
    begin
        width_x = XW'(image_width_reg);
        if (image_width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (width_x > XW'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(width_x - XW'(1));
        end

        if (image_height_reg == '0)
        begin
            hm1 = '0;
        end
        else if (image_height_reg > rcef_pkg::ROW_LIMIT)
        begin
            hm1 = '1;
        end
        else
        begin
            hm1 = RW'(image_height_reg - 13'd1);
        end

        c_eff    = (col_count_reg > wm1) ? wm1 : col_count_reg;
        r_eff    = (row_count_reg > hm1) ? hm1 : row_count_reg;
        last_col = (c_eff == wm1);
        last_row = (r_eff == hm1);

        new_mask[rcef_pkg::SLOT_UP_LEFT] = (r_eff != '0) && (c_eff != '0);
        new_mask[rcef_pkg::SLOT_UP]      = (r_eff != '0) && last_col;
        new_mask[rcef_pkg::SLOT_LEFT]    = last_row && (c_eff != '0);
        new_mask[rcef_pkg::SLOT_HERE]    = last_row && last_col;
    end

    // lowest pending slot goes out first
    always_comb
    begin
        if (s1_mask_reg[rcef_pkg::SLOT_UP_LEFT])
        begin
            sel = rcef_pkg::SLOT_UP_LEFT;
        end
        else if (s1_mask_reg[rcef_pkg::SLOT_UP])
        begin
            sel = rcef_pkg::SLOT_UP;
        end
        else if (s1_mask_reg[rcef_pkg::SLOT_LEFT])
        begin
            sel = rcef_pkg::SLOT_LEFT;
        end
        else
        begin
            sel = rcef_pkg::SLOT_HERE;
        end
        mask_left = s1_mask_reg & ~(4'b0001 << sel);
    end

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = s1_valid_reg && (s1_mask_reg != '0) && out_free;
    assign done     = s1_valid_reg && ((s1_mask_reg == '0) || (emit && (mask_left == '0)));
    assign s_tready = !s1_valid_reg || done;
    assign accept   = s_tvalid && s_tready;

    // line store: read old row value and store the new pixel at the same column
    rcef_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .re    (accept),
        .addr  (c_eff),
        .wdata (s_tdata[PW-1:0]),
        .rdata (above)
    );

    // result of the selected slot
    always_comb
    begin
        col_x   = XW'(s1_col_reg);
        colm1_x = col_x - XW'(1);
        case (sel)
            rcef_pkg::SLOT_UP_LEFT:
            begin
                res_row  = s1_row_reg - RW'(1);
                res_col  = colm1_x[rcef_pkg::OUT_COL_W-1:0];
                res_edge = rcef_pkg::edge_mag(above, left_reg, upleft_reg, s1_cur_reg);
            end
            rcef_pkg::SLOT_UP:
            begin
                res_row  = s1_row_reg - RW'(1);
                res_col  = col_x[rcef_pkg::OUT_COL_W-1:0];
                res_edge = rcef_pkg::edge_mag('0, s1_cur_reg, above, '0);
            end
            rcef_pkg::SLOT_LEFT:
            begin
                res_row  = s1_row_reg;
                res_col  = colm1_x[rcef_pkg::OUT_COL_W-1:0];
                res_edge = rcef_pkg::edge_mag(s1_cur_reg, '0, left_reg, '0);
            end
            default:
            begin
                res_row  = s1_row_reg;
                res_col  = col_x[rcef_pkg::OUT_COL_W-1:0];
                res_edge = rcef_pkg::edge_mag('0, '0, s1_cur_reg, '0);
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rcef_pkg::IMG_W_RESET;
            image_height_reg <= rcef_pkg::IMG_H_RESET;
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            left_reg         <= '0;
            upleft_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            s1_mask_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                // any write restarts the frame
                if (cfg_index == rcef_pkg::CFG_IMAGE_WIDTH)
                begin
                    image_width_reg <= cfg_data[rcef_pkg::IMG_W_W-1:0];
                end
                else
                begin
                    image_height_reg <= cfg_data[rcef_pkg::IMG_H_W-1:0];
                end
                row_count_reg <= '0;
                col_count_reg <= '0;
                left_reg      <= '0;
                upleft_reg    <= '0;
            end
            else
            begin
                if (accept)
                begin
                    if (last_col)
                    begin
                        col_count_reg <= '0;
                        row_count_reg <= last_row ? '0 : r_eff + RW'(1);
                    end
                    else
                    begin
                        col_count_reg <= c_eff + CW'(1);
                        row_count_reg <= r_eff;
                    end
                end
                if (done)
                begin
                    left_reg   <= s1_cur_reg;
                    upleft_reg <= above;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_mask_reg  <= new_mask;
            end
            else if (done)
            begin
                s1_valid_reg <= 1'b0;
                s1_mask_reg  <= '0;
            end
            else if (emit)
            begin
                s1_mask_reg <= mask_left;
            end

            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg <= s_tdata[PW-1:0];
            s1_row_reg <= r_eff;
            s1_col_reg <= c_eff;
        end
        if (emit)
        begin
            m_row_reg   <= res_row;
            m_col_reg   <= res_col;
            m_edge_reg  <= res_edge;
            m_last_reg  <= (mask_left == '0);
            m_frame_reg <= (sel == rcef_pkg::SLOT_HERE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_edge_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_frame_reg;

endmodule
